// ----- sv/postfix_expression_evaluator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the postfix expression evaluator.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while reset is low.
`define PEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define PEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PEE_ASSERT(lbl, prop, msg)
`define PEE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/pee_pkg.sv -----
// ----------------------------------------------------------------------------
// pee_pkg
// Types and character codes shared by the postfix evaluator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pee_pkg;

  // Characters the front end recognizes.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_UNDER   = 2'd2,
    ST_OVER    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PUSH = 2'd1,
    KIND_OP   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Input word: one character of the expression.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_word_t;

  // Output word: one result per expression.
  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
    logic [5:0]         stack_level;
  } out_word_t;

  // Command handed from the front end to the execution unit.
  typedef struct packed {
    kind_t              kind;
    op_t                op;
    logic signed [31:0] value;
    logic               end_flag;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/pee_ram.sv -----
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/pee_front.sv -----
// ----------------------------------------------------------------------------
// pee_front
// Classifies incoming characters, builds decimal numbers in fixed point and
// issues one command per accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             char_valid,
  output logic                  char_ready,
  input  pee_pkg::in_word_t     char_word,
  output logic                  cmd_push,
  output pee_pkg::cmd_t         cmd_word,
  input  wire logic             cmd_ready
);

  // Weight of the k-th fractional digit, truncated; entry 7 is never used.
  localparam logic [31:0] FRAC_STEP [8] = '{
    32'((64'd1 << FRAC_BITS) / 64'd10),
    32'((64'd1 << FRAC_BITS) / 64'd100),
    32'((64'd1 << FRAC_BITS) / 64'd1000),
    32'((64'd1 << FRAC_BITS) / 64'd10000),
    32'((64'd1 << FRAC_BITS) / 64'd100000),
    32'((64'd1 << FRAC_BITS) / 64'd1000000),
    32'((64'd1 << FRAC_BITS) / 64'd10000000),
    32'd0
  };
  localparam logic [36:0] POS_MAX = 37'h0_7FFF_FFFF;

  logic [31:0] acc;
  logic        in_num;
  logic        pt;
  logic [2:0]  fc;

  logic [7:0]  c;
  logic        is_digit, is_point, numeric, is_op, accept;
  logic [3:0]  d;
  logic [31:0] base_acc, new_acc;
  logic        base_pt, new_pt;
  logic [2:0]  base_fc, new_fc;
  logic [36:0] int_sum, frac_sum;
  logic [35:0] frac_prod;
  logic [7:0]  d_wide;

  assign c        = char_word.character;
  assign is_digit = (c >= pee_pkg::CH_0) && (c <= pee_pkg::CH_9);
  assign is_point = (c == pee_pkg::CH_POINT);
  assign numeric  = is_digit || is_point;
  assign is_op    = (c == pee_pkg::CH_PLUS) || (c == pee_pkg::CH_MINUS) ||
                    (c == pee_pkg::CH_STAR) || (c == pee_pkg::CH_SLASH);
  assign d_wide   = c - pee_pkg::CH_0;
  assign d        = d_wide[3:0];
  assign accept   = char_valid && cmd_ready;
  assign char_ready = cmd_ready;

  // A new number starts from a cleared builder.
  assign base_acc = in_num ? acc : 32'd0;
  assign base_pt  = in_num ? pt  : 1'b0;
  assign base_fc  = in_num ? fc  : 3'd0;

  // Integer digit: acc*10 + d*2^F; fraction digit: acc + d*step.
  assign int_sum   = ({5'd0, base_acc} << 3) + ({5'd0, base_acc} << 1) +
                     ({33'd0, d} << FRAC_BITS);
  assign frac_prod = 36'(d) * 36'(FRAC_STEP[base_fc]);
  assign frac_sum  = {5'd0, base_acc} + {1'b0, frac_prod};

  // Next state of the number builder for a numeric character.
  always_comb begin
    new_acc = base_acc;
    new_pt  = base_pt;
    new_fc  = base_fc;
    if (is_point) begin
      new_pt = 1'b1;
    end else if (!base_pt) begin
      new_acc = (int_sum > POS_MAX) ? POS_MAX[31:0] : int_sum[31:0];
    end else if (base_fc != 3'd7) begin
      new_fc  = base_fc + 3'd1;
      new_acc = (frac_sum > POS_MAX) ? POS_MAX[31:0] : frac_sum[31:0];
    end
  end

  // Command for the current character.
  always_comb begin
    cmd_word.kind     = pee_pkg::KIND_NONE;
    cmd_word.op       = pee_pkg::OP_ADD;
    cmd_word.value    = '0;
    cmd_word.end_flag = char_word.last;
    if (in_num && !numeric) begin
      cmd_word.kind  = pee_pkg::KIND_PUSH;
      cmd_word.value = acc;
    end else if (numeric) begin
      if (char_word.last) begin
        cmd_word.kind  = pee_pkg::KIND_PUSH;
        cmd_word.value = new_acc;
      end
    end else if (is_op) begin
      cmd_word.kind = pee_pkg::KIND_OP;
      unique case (c)
        pee_pkg::CH_PLUS:  cmd_word.op = pee_pkg::OP_ADD;
        pee_pkg::CH_MINUS: cmd_word.op = pee_pkg::OP_SUB;
        pee_pkg::CH_STAR:  cmd_word.op = pee_pkg::OP_MUL;
        default:           cmd_word.op = pee_pkg::OP_DIV;
      endcase
    end else if (c != pee_pkg::CH_SPACE) begin
      cmd_word.kind = pee_pkg::KIND_PUSH;
    end
  end

  assign cmd_push = accept;

  // Number builder registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      in_num <= 1'b0;
      pt     <= 1'b0;
      fc     <= '0;
    end else if (accept) begin
      if (char_word.last || (in_num && !numeric)) begin
        acc    <= '0;
        in_num <= 1'b0;
        pt     <= 1'b0;
        fc     <= '0;
      end else if (numeric) begin
        acc    <= new_acc;
        in_num <= 1'b1;
        pt     <= new_pt;
        fc     <= new_fc;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/pee_queue.sv -----
// ----------------------------------------------------------------------------
// pee_queue
// Two-entry command queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "postfix_expression_evaluator_assert.svh"

module pee_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  pee_pkg::cmd_t  push_word,
  output logic           push_ready,
  output logic           pop_valid,
  output pee_pkg::cmd_t  pop_word,
  input  wire logic      pop
);

  pee_pkg::cmd_t entry [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_word   = entry[rp];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= push_word;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= !wp;
      end
      if (do_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `PEE_ASSERT(a_cnt_range, (cnt != 2'd3), "queue fill count out of range")
  `PEE_ASSERT(a_ptr_sync, ((cnt == 2'd0) || (cnt == 2'd2)) |-> (wp == rp),
              "queue pointers disagree with fill count")

endmodule

`default_nettype wire

// ----- sv/pee_back.sv -----
// ----------------------------------------------------------------------------
// pee_back
// Execution unit: operand stack in RAM, add/subtract, multiply, bit-serial
// divide, error tracking and result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

`include "postfix_expression_evaluator_assert.svh"

module pee_back #(
  parameter int STACK_DEPTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  pee_pkg::cmd_t      cmd_word,
  output logic               cmd_pop,
  output logic               res_valid,
  input  wire logic          res_ready,
  output pee_pkg::out_word_t res_word
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = 32 + FRAC_BITS;
  localparam int NW = $clog2(DW + 1);
  localparam logic [DW-1:0] MAG_MIN = DW'(64'h8000_0000);
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD_B = 9'b000000010,
    S_RD_A = 9'b000000100,
    S_EXEC = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_DFIX = 9'b001000000,
    S_WB   = 9'b010000000,
    S_END  = 9'b100000000
  } state_t;

  state_t             state;
  pee_pkg::cmd_t      cmd;
  logic [CW-1:0]      count;
  logic signed [31:0] last_op;
  pee_pkg::status_t   err;
  logic signed [31:0] op_a, op_b, res;
  logic signed [63:0] prod;
  logic [DW-1:0]      div_q;
  logic [31:0]        div_r, div_d;
  logic [NW-1:0]      div_n;
  logic               div_neg;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  logic [CW-1:0]      cm1, cm2;
  logic               full, short;
  logic signed [32:0] sum;
  logic signed [63:0] shifted;
  logic [32:0]        rem_sh, rem_sub;
  logic [DW-1:0]      neg_q;
  logic [31:0]        abs_a, abs_b;

  assign cm1   = count - CW'(1);
  assign cm2   = count - CW'(2);
  assign full  = (count == CW'(STACK_DEPTH));
  assign short = (count < CW'(2));
  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  // Operand stack memory.
  pee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stack port control: push from idle, operator writeback, two operand reads.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = cmd_word.value;
    ram_re    = 1'b0;
    ram_raddr = cm1[AW-1:0];
    if (cmd_pop && (cmd_word.kind == pee_pkg::KIND_PUSH) && !full) begin
      ram_we = 1'b1;
    end else if (state == S_WB) begin
      ram_we    = 1'b1;
      ram_waddr = cm2[AW-1:0];
      ram_wdata = res;
    end
    if (cmd_pop && (cmd_word.kind == pee_pkg::KIND_OP) && !short) begin
      ram_re = 1'b1;
    end else if (state == S_RD_B) begin
      ram_re    = 1'b1;
      ram_raddr = cm2[AW-1:0];
    end
  end

  // Datapath helpers.
  assign sum     = {op_a[31], op_a} + (cmd.op == pee_pkg::OP_SUB ?
                   -{op_b[31], op_b} : {op_b[31], op_b});
  assign shifted = prod >>> FRAC_BITS;
  assign rem_sh  = {div_r, div_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, div_d};
  assign neg_q   = -div_q;
  assign abs_a   = op_a[31] ? 32'(-op_a) : op_a;
  assign abs_b   = op_b[31] ? 32'(-op_b) : op_b;

  // Sequencer and stack state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      last_op   <= '0;
      err       <= pee_pkg::ST_OK;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd <= cmd_word;
            unique case (cmd_word.kind)
              pee_pkg::KIND_OP: begin
                if (short) begin
                  if (err == pee_pkg::ST_OK) err <= pee_pkg::ST_UNDER;
                  state <= S_END;
                end else begin
                  state <= S_RD_B;
                end
              end
              pee_pkg::KIND_PUSH: begin
                if (full) begin
                  if (err == pee_pkg::ST_OK) err <= pee_pkg::ST_OVER;
                end else begin
                  count <= count + CW'(1);
                end
                state <= S_END;
              end
              default: state <= S_END;
            endcase
          end
        end
        S_RD_B: begin
          op_b  <= ram_rdata;
          state <= S_RD_A;
        end
        S_RD_A: begin
          op_a  <= ram_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          unique case (cmd.op)
            pee_pkg::OP_ADD, pee_pkg::OP_SUB: begin
              res   <= (sum[32] != sum[31]) ? (sum[32] ? S_MIN : S_MAX) : sum[31:0];
              state <= S_WB;
            end
            pee_pkg::OP_MUL: begin
              prod  <= op_a * op_b;
              state <= S_MUL;
            end
            default: begin
              if (op_b == 0) begin
                count <= cm2;
                if (err == pee_pkg::ST_OK) err <= pee_pkg::ST_DIVZERO;
                state <= S_END;
              end else begin
                div_q   <= {abs_a, {FRAC_BITS{1'b0}}};
                div_r   <= '0;
                div_d   <= abs_b;
                div_n   <= NW'(DW);
                div_neg <= op_a[31] ^ op_b[31];
                state   <= S_DIV;
              end
            end
          endcase
        end
        S_MUL: begin
          if (shifted > 64'sd2147483647) begin
            res <= S_MAX;
          end else if (shifted < -64'sd2147483648) begin
            res <= S_MIN;
          end else begin
            res <= shifted[31:0];
          end
          state <= S_WB;
        end
        S_DIV: begin
          // One quotient bit per cycle, restoring form.
          if (!rem_sub[32]) begin
            div_r <= rem_sub[31:0];
            div_q <= {div_q[DW-2:0], 1'b1};
          end else begin
            div_r <= rem_sh[31:0];
            div_q <= {div_q[DW-2:0], 1'b0};
          end
          div_n <= div_n - NW'(1);
          if (div_n == NW'(1)) begin
            state <= S_DFIX;
          end
        end
        S_DFIX: begin
          if (div_neg) begin
            res <= (div_q > MAG_MIN) ? S_MIN : neg_q[31:0];
          end else begin
            res <= (div_q >= MAG_MIN) ? S_MAX : div_q[31:0];
          end
          state <= S_WB;
        end
        S_WB: begin
          last_op <= res;
          count   <= cm1;
          state   <= S_END;
        end
        S_END: begin
          if (!cmd.end_flag) begin
            state <= S_IDLE;
          end else if (!res_valid || res_ready) begin
            res_word.result      <= last_op;
            res_word.status      <= err;
            res_word.stack_level <= 6'(count);
            res_valid <= 1'b1;
            count     <= '0;
            last_op   <= '0;
            err       <= pee_pkg::ST_OK;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PEE_ASSERT(a_count_bound, (count <= CW'(STACK_DEPTH)),
              "stack count above depth")
  `PEE_ASSERT(a_div_nonzero, (state == S_DIV) |-> (div_d != 32'd0),
              "divide started with zero divisor")
  `PEE_ASSERT(a_wb_operands, (state == S_WB) |-> (count >= CW'(2)),
              "writeback without two operands")
  `PEE_ASSERT(a_emit_clears, $rose(res_valid) |-> (count == '0 && err == pee_pkg::ST_OK),
              "expression state not cleared at result")

endmodule

`default_nettype wire

// ----- sv/postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Character-serial postfix evaluator in signed fixed point.
// ----------------------------------------------------------------------------
// Characters enter one word per cycle while the two-entry command queue has
// room; the execution unit drains it at its own pace. Per character the unit
// passes through idle and a closing state for a space, a number or a pushed
// zero; add and subtract also read both operands, execute and write back,
// multiply adds a multiply state, and a divide adds the one-bit-per-cycle
// divider and a sign fix-up; a divide by zero stops after execute. The final
// character of an expression emits one result word in its closing state,
// waiting there only while the previous result word is still unaccepted: last
// operator value, first error, and operand count. The operand stack is a RAM
// of STACK_DEPTH words with one write and one registered read port;
// operators read their two operands in consecutive cycles.
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          char_valid,
  output logic               char_ready,
  input  pee_pkg::in_word_t  char_word,
  output logic               res_valid,
  input  wire logic          res_ready,
  output pee_pkg::out_word_t res_word
);

  logic          f_push, q_ready, q_valid, q_pop;
  pee_pkg::cmd_t f_cmd, q_cmd;

  // Character classification and number building.
  pee_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_word  (char_word),
    .cmd_push   (f_push),
    .cmd_word   (f_cmd),
    .cmd_ready  (q_ready)
  );

  // Decoupling queue.
  pee_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_word  (f_cmd),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_word   (q_cmd),
    .pop        (q_pop)
  );

  // Stack and arithmetic.
  pee_back #(.STACK_DEPTH(STACK_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_word  (q_cmd),
    .cmd_pop   (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

endmodule

`default_nettype wire

// ----- verif/tb_postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Streams characters of postfix expressions into the block, predicts the one
// result word per expression with a fixed-point model of its own, and checks
// every result word in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int FRAC = 16;

  // Tracks evaluator state and holds the expected result words.
  class rpn_scoreboard;
    logic signed [31:0] stk[DEPTH];
    int count;
    logic signed [31:0] last_val;
    logic signed [31:0] accum;
    bit in_num;
    bit after_pt;
    int frac_cnt;
    pee_pkg::status_t err;
    pee_pkg::out_word_t pending[$];
    int mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      count = 0;
      last_val = 0;
      accum = 0;
      in_num = 0;
      after_pt = 0;
      frac_cnt = 0;
      err = pee_pkg::ST_OK;
    endfunction

    function logic signed [31:0] sat(logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void flag(pee_pkg::status_t s);
      if (err == pee_pkg::ST_OK) err = s;
    endfunction

    function void push(logic signed [31:0] v);
      if (count >= DEPTH) begin
        flag(pee_pkg::ST_OVER);
        return;
      end
      stk[count] = v;
      count++;
    endfunction

    function void add_digit(logic [7:0] c);
      logic signed [65:0] v;
      longint unsigned step;
      v = accum;
      if (c == pee_pkg::CH_POINT) begin
        after_pt = 1;
        return;
      end
      if (!after_pt) begin
        v = v * 10 + ((66'(c - pee_pkg::CH_0)) <<< FRAC);
      end else begin
        if (frac_cnt >= 7) return;
        frac_cnt++;
        step = (64'd1 << FRAC) / (10 ** frac_cnt);
        v = v + 66'(c - pee_pkg::CH_0) * 66'(step);
      end
      accum = sat(v);
    endfunction

    function void end_number();
      push(accum);
      in_num = 0;
      after_pt = 0;
      frac_cnt = 0;
      accum = 0;
    endfunction

    function void operate(logic [7:0] c);
      logic signed [65:0] a, b, r;
      if (count < 2) begin
        flag(pee_pkg::ST_UNDER);
        return;
      end
      b = stk[count-1];
      a = stk[count-2];
      count -= 2;
      if (c == pee_pkg::CH_PLUS) r = a + b;
      else if (c == pee_pkg::CH_MINUS) r = a - b;
      else if (c == pee_pkg::CH_STAR) r = (a * b) >>> FRAC;
      else begin
        if (b == 0) begin
          flag(pee_pkg::ST_DIVZERO);
          return;
        end
        r = (a <<< FRAC) / b;
      end
      last_val = sat(r);
      push(last_val);
    endfunction

    // Notes one accepted input word.
    function void note_char(pee_pkg::in_word_t w);
      bit numeric;
      pee_pkg::out_word_t o;
      numeric = (w.character >= pee_pkg::CH_0 && w.character <= pee_pkg::CH_9) ||
                w.character == pee_pkg::CH_POINT;
      if (in_num) begin
        if (numeric) add_digit(w.character);
        else end_number();
      end else if (numeric) begin
        in_num = 1;
        after_pt = 0;
        frac_cnt = 0;
        accum = 0;
        add_digit(w.character);
      end else if (w.character == pee_pkg::CH_SPACE) begin
      end else if (w.character == pee_pkg::CH_PLUS || w.character == pee_pkg::CH_MINUS ||
                   w.character == pee_pkg::CH_STAR || w.character == pee_pkg::CH_SLASH) begin
        operate(w.character);
      end else begin
        push(0);
      end
      if (w.last) begin
        if (in_num) end_number();
        o.result = last_val;
        o.status = err;
        o.stack_level = 6'(count);
        pending.push_back(o);
        clear();
      end
    endfunction

    // Checks one accepted result word.
    function void check_result(pee_pkg::out_word_t got);
      pee_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got.result !== exp_w.result || got.status !== exp_w.status ||
          got.stack_level !== exp_w.stack_level) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected result %h status %0d level %0d, got %h %0d %0d",
                   exp_w.result, exp_w.status, exp_w.stack_level,
                   got.result, got.status, got.stack_level);
      end
    endfunction
  endclass

  logic clk, rst, char_valid, char_ready, res_valid, res_ready;
  pee_pkg::in_word_t char_word;
  pee_pkg::out_word_t res_word;
  rpn_scoreboard sb;
  bit quiet;
  int sent;

  postfix_expression_evaluator dut (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_ready(char_ready), .char_word(char_word),
    .res_valid(res_valid), .res_ready(res_ready), .res_word(res_word)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("** postfix_expression_evaluator: FAILED **");
    $finish;
  end

  // Monitor both channels at the clock edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && char_ready) sb.note_char(char_word);
      if (res_valid && res_ready) sb.check_result(res_word);
    end
  end

  // Result side back-pressure in random bursts.
  initial begin
    int n;
    res_ready <= 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      res_ready <= 1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        res_ready <= 0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Sends one character and waits for its acceptance.
  task automatic send_char(logic [7:0] c, bit lst);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      char_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    char_valid <= 1;
    char_word <= '{character: c, last: lst};
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Random numeral: integer digits, maybe a point and fraction digits.
  function automatic string rand_number();
    string s;
    int k;
    s = "";
    k = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : $urandom_range(1, 3);
    repeat (k) s = {s, string'(8'(pee_pkg::CH_0 + $urandom_range(0, 9)))};
    if ($urandom_range(0, 1)) begin
      s = {s, "."};
      repeat ($urandom_range(0, 9))
        s = {s, string'(8'(pee_pkg::CH_0 + $urandom_range(0, 9)))};
    end
    return s;
  endfunction

  function automatic byte rand_op();
    case ($urandom_range(0, 3))
      0: return pee_pkg::CH_PLUS;
      1: return pee_pkg::CH_MINUS;
      2: return pee_pkg::CH_STAR;
      default: return pee_pkg::CH_SLASH;
    endcase
  endfunction

  // Mostly well-formed expressions, with some noise and broken ones.
  function automatic string rand_expr();
    string s;
    int depth, steps;
    s = "";
    depth = 0;
    steps = $urandom_range(1, 8);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        s = {s, string'(8'($urandom_range(0, 255)))};
      end else if (depth < 2 || $urandom_range(0, 1)) begin
        s = {s, ($urandom_range(0, 6) == 0) ? "0" : rand_number(), " "};
        depth++;
      end else begin
        s = {s, string'(rand_op())};
        if ($urandom_range(0, 2) == 0) s = {s, " "};
        depth--;
      end
    end
    while (depth > 1 && $urandom_range(0, 4) != 0) begin
      s = {s, string'(rand_op())};
      depth--;
    end
    return s;
  endfunction

  initial begin
    string s;
    sb = new();
    quiet = 0;
    sent = 0;
    rst <= 1;
    char_valid <= 0;
    char_word <= '0;
    repeat (12) @(posedge clk);
    rst <= 0;
    // Directed expressions.
    send_string("3 4+");
    send_string("10 4-");
    send_string("2.5 1.25*");
    send_string("7 2/");
    send_string("5 0/");
    send_string("+");
    send_string("1.99999999 3..5 *");
    send_string("99999999 9*");
    send_string("1 2");
    send_string("0 0.0000001-");
    s = "";
    repeat (33) s = {s, "1 "};
    send_string({s, "+"});
    send_string("4 a-");
    send_char(8'hff, 0);
    send_char(8'h00, 1);
    send_string("42");
    // Pause until every expected word has come back.
    char_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    // Random expressions.
    while (sent < 1950) begin
      if (sent > 1700) quiet = 1;
      send_string(rand_expr());
    end
    char_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("** postfix_expression_evaluator: PASSED **");
    else
      $display("** postfix_expression_evaluator: FAILED **");
    $finish;
  end
endmodule
